### design/lcsr_pkg.sv
// ----------------------------------------------------------------------------
// lcsr_pkg
// Shared types and codes for the line column span rasterizer: the span word,
// the shared adder control and status, and the adder operation codes.
// ----------------------------------------------------------------------------
package lcsr_pkg;

    localparam logic [1:0] ALU_SUB_DX = 2'd0;
    localparam logic [1:0] ALU_ADD_DX = 2'd1;
    localparam logic [1:0] ALU_ADD_DY = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic signed [7:0] a;
    } alu_ctrl_t;

    typedef struct packed {
        logic signed [7:0] res;
        logic              neg;
        logic              zero;
    } alu_stat_t;

    typedef struct packed {
        logic [5:0] screen_column;
        logic [6:0] anchor_row;
        logic [6:0] span_length;
        logic       toward_top;
        logic       last_span;
    } span_t;

endpackage

### design/lcsr_if.sv
// ----------------------------------------------------------------------------
// lcsr_in_if / lcsr_out_if
// Valid/ready channels: line endpoints in, column spans out.
// ----------------------------------------------------------------------------
interface lcsr_in_if;
    logic              valid;
    logic              ready;
    logic signed [5:0] start_x;
    logic signed [5:0] start_y;
    logic signed [5:0] end_x;
    logic signed [5:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

interface lcsr_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] screen_column;
    logic [6:0] anchor_row;
    logic [6:0] span_length;
    logic       toward_top;
    logic       last_span;

    modport source (output valid, output screen_column, output anchor_row,
                    output span_length, output toward_top, output last_span,
                    input ready);
    modport sink (input valid, input screen_column, input anchor_row,
                  input span_length, input toward_top, input last_span,
                  output ready);
endinterface

### design/lcsr_alu.sv
// ----------------------------------------------------------------------------
// lcsr_alu
// Shared add/subtract unit: adds or subtracts the run, or adds the rise,
// and flags a negative or zero result.
// ----------------------------------------------------------------------------
module lcsr_alu (
    input  lcsr_pkg::alu_ctrl_t ctrl,
    input  logic [5:0]          dx,
    input  logic signed [6:0]   dy,
    output lcsr_pkg::alu_stat_t stat
);
    import lcsr_pkg::*;

    logic signed [7:0] dx_ext;
    logic signed [7:0] dy_ext;
    logic signed [7:0] res;

    assign dx_ext = {2'b00, dx};
    assign dy_ext = {dy[6], dy};

    always_comb
    begin
        case (ctrl.op)
            ALU_SUB_DX: res = ctrl.a - dx_ext;
            ALU_ADD_DX: res = ctrl.a + dx_ext;
            ALU_ADD_DY: res = ctrl.a + dy_ext;
            default:    res = ctrl.a;
        endcase
    end

    assign stat.res  = res;
    assign stat.neg  = res[7];
    assign stat.zero = (res == 8'sd0);

endmodule

### design/lcsr_out_reg.sv
// ----------------------------------------------------------------------------
// lcsr_out_reg
// Output register for span words; holds a word until the sink takes it.
// ----------------------------------------------------------------------------
module lcsr_out_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  lcsr_pkg::span_t span,
    output logic            free,
    lcsr_out_if.source      span_out
);
    import lcsr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    span_t span_reg;

    assign free = !valid_reg || span_out.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (span_out.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            span_reg <= span;
        end
    end

    assign span_out.valid         = valid_reg;
    assign span_out.screen_column = span_reg.screen_column;
    assign span_out.anchor_row    = span_reg.anchor_row;
    assign span_out.span_length   = span_reg.span_length;
    assign span_out.toward_top    = span_reg.toward_top;
    assign span_out.last_span     = span_reg.last_span;

endmodule

### design/line_column_span_rasterizer_core.sv
// ----------------------------------------------------------------------------
// line_column_span_rasterizer_core
// Steps a line column by column and emits one vertical pixel span per column,
// with the anchor row tracked as an exact quotient and remainder.
//
//   channel    dir  word
//   line_in    in   start_x, start_y, end_x, end_y (signed, centered)
//   span_out   out  screen_column, anchor_row, span_length, toward_top,
//                   last_span
//
// A vertical line goes straight to emitting its single span. Otherwise one
// shared adder does the span length division, then per column the remainder
// correction, rounding and next-column step. The span output register stalls
// the sequencer only while a word is waiting. line_in.ready is high only
// when idle.
// Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module line_column_span_rasterizer_core #(
    parameter int CANVAS_WIDTH  = 64,
    parameter int CANVAS_HEIGHT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lcsr_in_if.sink    line_in,
    lcsr_out_if.source span_out
);
    import lcsr_pkg::*;

    localparam logic [5:0] HALF_W = 6'(CANVAS_WIDTH / 2);
    localparam logic [6:0] HALF_H = 7'(CANVAS_HEIGHT / 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEN   = 3'd1;
    localparam logic [2:0] S_NORM  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]        state_reg,  state_next;
    logic signed [5:0] col_reg,    col_next;
    logic signed [5:0] stop_reg,   stop_next;
    logic [5:0]        dx_reg,     dx_next;
    logic signed [6:0] dy_reg,     dy_next;
    logic signed [6:0] q_reg,      q_next;
    logic signed [6:0] y_reg,      y_next;
    logic signed [7:0] r_reg,      r_next;
    logic [6:0]        len_reg,    len_next;
    logic              up_reg,     up_next;

    logic signed [5:0] x1, y1, x2, y2;
    logic signed [6:0] dx_raw, dy_raw, dx_abs, dy_norm, dy_abs, dv_abs;
    logic              swap;
    logic signed [5:0] lo, hi, ylo, ymin;
    logic              roundup;

    alu_ctrl_t alu_ctrl;
    alu_stat_t alu_stat;
    span_t     span;
    logic      span_load;
    logic      out_free;

    lcsr_alu u_alu (
        .ctrl (alu_ctrl),
        .dx   (dx_reg),
        .dy   (dy_reg),
        .stat (alu_stat)
    );

    lcsr_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (span_load),
        .span     (span),
        .free     (out_free),
        .span_out (span_out)
    );

    assign x1 = line_in.start_x;
    assign y1 = line_in.start_y;
    assign x2 = line_in.end_x;
    assign y2 = line_in.end_y;

    assign dx_raw  = {x1[5], x1} - {x2[5], x2};
    assign dy_raw  = {y1[5], y1} - {y2[5], y2};
    assign swap    = dx_raw[6];
    assign dx_abs  = swap ? -dx_raw : dx_raw;
    assign dy_norm = swap ? -dy_raw : dy_raw;
    assign dy_abs  = dy_norm[6] ? -dy_norm : dy_norm;
    assign dv_abs  = dy_raw[6] ? -dy_raw : dy_raw;
    assign lo      = swap ? x1 : x2;
    assign hi      = swap ? x2 : x1;
    assign ylo     = swap ? y1 : y2;
    assign ymin    = (y1 < y2) ? y1 : y2;

    assign line_in.ready = (state_reg == S_IDLE);

    assign roundup = q_reg[6] ? (!alu_stat.neg && !alu_stat.zero) : !alu_stat.neg;

    assign span.screen_column = col_reg[5:0] + HALF_W;
    assign span.anchor_row    = HALF_H - y_reg[6:0];
    assign span.span_length   = len_reg;
    assign span.toward_top    = up_reg;
    assign span.last_span     = (col_reg == stop_reg);

    always_comb
    begin
        alu_ctrl.a = r_reg;
        case (state_reg)
            S_LEN:   alu_ctrl.op = ALU_SUB_DX;
            S_NORM:  alu_ctrl.op = r_reg[7] ? ALU_ADD_DX : ALU_SUB_DX;
            S_ROUND:
            begin
                alu_ctrl.op = ALU_SUB_DX;
                alu_ctrl.a  = {r_reg[6:0], 1'b0};
            end
            S_EMIT:  alu_ctrl.op = ALU_ADD_DY;
            default: alu_ctrl.op = ALU_SUB_DX;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        stop_next  = stop_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        q_next     = q_reg;
        y_next     = y_reg;
        r_next     = r_reg;
        len_next   = len_reg;
        up_next    = up_reg;
        span_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (line_in.valid)
                begin
                    if (dx_raw == 7'sd0)
                    begin
                        col_next   = x1;
                        stop_next  = x1;
                        y_next     = {ymin[5], ymin};
                        len_next   = dv_abs + 7'd1;
                        up_next    = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        col_next  = lo;
                        stop_next = hi - 6'sd1;
                        dx_next   = dx_abs[5:0];
                        dy_next   = dy_norm;
                        q_next    = {ylo[5], ylo};
                        up_next   = !dy_norm[6];
                        if (dy_norm == 7'sd0)
                        begin
                            len_next   = 7'd1;
                            r_next     = 8'sd0;
                            state_next = S_NORM;
                        end
                        else
                        begin
                            len_next   = 7'd0;
                            r_next     = {1'b0, dy_abs};
                            state_next = S_LEN;
                        end
                    end
                end
            end
            S_LEN:
            begin
                if (!r_reg[7] && (r_reg != 8'sd0))
                begin
                    r_next   = alu_stat.res;
                    len_next = len_reg + 7'd1;
                end
                else
                begin
                    r_next     = 8'sd0;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (r_reg[7])
                begin
                    r_next = alu_stat.res;
                    q_next = q_reg - 7'sd1;
                end
                else if (!alu_stat.neg)
                begin
                    r_next = alu_stat.res;
                    q_next = q_reg + 7'sd1;
                end
                else
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                y_next     = q_reg + {6'd0, roundup};
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    span_load = 1'b1;
                    if (col_reg == stop_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 6'sd1;
                        r_next     = alu_stat.res;
                        state_next = S_NORM;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        stop_reg <= stop_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        q_reg    <= q_next;
        y_reg    <= y_next;
        r_reg    <= r_next;
        len_reg  <= len_next;
        up_reg   <= up_next;
    end

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (!r_reg[7] && (r_reg[6:0] < {1'b0, dx_reg})))
        else $error("remainder out of range at rounding");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        span_load |-> (len_reg != 7'd0))
        else $error("span with zero length");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (span_load && span.last_span) |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after last span");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        span_load |-> out_free)
        else $error("span word overwritten");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN) |-> (len_reg < 7'd64))
        else $error("span length count overflow");

endmodule
